### rtl/core/tcst_pkg.sv
// Shared types and constants of the toroidal chunk slot table.
package tcst_pkg;

   // Fixed field widths
   localparam int COORD_BITS     = 24;
   localparam int DEF_MAX_RADIUS = 7;
   localparam int CMD_W          = 2;
   localparam int STATUS_W       = 3;
   localparam int SLOT_W         = 4;
   localparam int ADDR_OUT_W     = 12;
   localparam int RADIUS_W       = 3;
   localparam int CSR_INDEX_W    = 2;
   localparam int WORD_W         = 32;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 3'd7;

   // Commands
   localparam logic [CMD_W-1:0] CMD_MOVE     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_STORE    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_MOVED   = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_STORED  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_CLEARED = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED = 3'd4;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS_X = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS_Y = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS_Z = 2'd2;

   typedef struct packed {
      logic        [CMD_W-1:0]      command;
      logic signed [COORD_BITS-1:0] coord_x;
      logic signed [COORD_BITS-1:0] coord_y;
      logic signed [COORD_BITS-1:0] coord_z;
      logic        [WORD_W-1:0]     index_count;
      logic        [WORD_W-1:0]     instance_count;
      logic        [WORD_W-1:0]     first_index;
      logic        [WORD_W-1:0]     vertex_base;
      logic        [WORD_W-1:0]     first_instance;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [SLOT_W-1:0]     slot_x;
      logic [SLOT_W-1:0]     slot_y;
      logic [SLOT_W-1:0]     slot_z;
      logic [ADDR_OUT_W-1:0] slot_address;
      logic [WORD_W-1:0]     freed_vertex_base;
      logic [WORD_W-1:0]     freed_first_index;
      logic [WORD_W-1:0]     freed_first_instance;
   } rsp_type;

endpackage

### rtl/core/toroidal_chunk_slot_table_core.sv
// Top level of the toroidal chunk slot table: sequencer, window arithmetic and record store.
//
// Keeps draw records for a (2rx+1)*(2ry+1)*(2rz+1) window of chunks around the view position in one
// record RAM addressed as a torus, so moving the view only shifts the start corner.
// One request is worked at a time. A move waits on the shared modulo unit, which
// retires four dividend bits per cycle on all three axes at once; a store or clear
// inside the window passes the window check, slot address multiply and the
// read-modify-write of the record RAM; one outside the window ends after the window
// check, and an unused command goes straight to the result. A stalled result holds
// the next one in the done state. The result register frees the request side, so the
// next request is taken while a result is still waiting.
// After reset the block sweeps all (2*MAX_RADIUS+1)^3 record RAM entries (3375 by
// default) to empty, one entry a cycle, and stalls requests meanwhile; radius
// registers may be written at any idle time.
module toroidal_chunk_slot_table_core #(
   parameter int MAX_RADIUS = tcst_pkg::DEF_MAX_RADIUS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  tcst_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output tcst_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tcst_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tcst_pkg::RADIUS_W-1:0]        csr_data
);

   import tcst_pkg::*;

   localparam int SIDE_MAX = 2 * MAX_RADIUS + 1;
   localparam int DEPTH    = SIDE_MAX * SIDE_MAX * SIDE_MAX;
   localparam int AW       = $clog2(DEPTH);
   localparam int SW       = $clog2(SIDE_MAX + 1);
   localparam int WIDE_W   = COORD_BITS + 2;
   localparam int PLW      = 2 * SW;
   localparam int FAW      = 3 * SW;

   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] vertex_base;
      logic [WORD_W-1:0] first_index;
      logic [WORD_W-1:0] first_instance;
   } rec_type;

   localparam int MEM_W = $bits(rec_type);

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_MSTART,
      ST_MWAIT,
      ST_REL,
      ST_SLOT,
      ST_ADDR,
      ST_READ,
      ST_CHECK,
      ST_DONE
   } state_type;

   state_type               state_ff;
   logic [AW-1:0]           clr_addr_ff;
   logic [RADIUS_W-1:0]     radius_ff [3];
   logic [COORD_BITS-1:0]   view_pos_ff [3];
   logic [SW-1:0]           start_corner_ff [3];
   req_type                 req_ff;
   logic [SW-1:0]           rel_ff [3];
   logic [SW-1:0]           scm_ff [3];
   logic                    inside_ff;
   logic [SW-1:0]           slot_ff [3];
   logic [PLW-1:0]          plane_ff;
   logic [AW-1:0]           addr_ff;
   rsp_type                 res_ff;
   rsp_type                 rsp_data_ff;
   logic                    rsp_valid_ff;

   logic [COORD_BITS-1:0]   coord [3];
   logic [SW-2:0]           rad_sat [3];
   logic [SW-1:0]           side [3];
   logic [WIDE_W-1:0]       rel_full [3];
   logic [WIDE_W-1:0]       dividend [3];
   logic                    inside_axis [3];
   logic [SW-1:0]           scm [3];
   logic [SW:0]             slot_sum [3];
   logic [SW-1:0]           slot_next [3];
   logic [FAW-1:0]          addr_full;

   logic                    mod_start;
   logic                    mod_busy;
   logic                    mod_done;
   logic [SW-1:0]           mod_rem [3];

   logic                    ram_we;
   logic [AW-1:0]           ram_waddr;
   logic [MEM_W-1:0]        ram_wdata;
   logic                    ram_re;
   logic [MEM_W-1:0]        ram_rdata;
   rec_type                 rd_rec;
   rec_type                 chk_rec;
   logic                    chk_we;
   rsp_type                 chk_rsp;

   // Value modulo a small side, one restoring step per bit
   function automatic logic [SW-1:0] reduce_mod(input logic [SW-1:0] value,
                                                input logic [SW-1:0] modulus);
      logic [SW:0]   trial;
      logic [SW-1:0] rem;
      rem = '0;
      for (int i = SW - 1; i >= 0; i--) begin
         trial = {rem, value[i]};
         if (trial >= {1'b0, modulus}) begin
            trial = trial - {1'b0, modulus};
         end
         rem = trial[SW-1:0];
      end
      return rem;
   endfunction

   // Per-axis window arithmetic
   assign coord[0] = req_ff.coord_x;
   assign coord[1] = req_ff.coord_y;
   assign coord[2] = req_ff.coord_z;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         rad_sat[a] = (int'(radius_ff[a]) > MAX_RADIUS) ? (SW-1)'(MAX_RADIUS)
                                                        : (SW-1)'(radius_ff[a]);
         side[a] = {rad_sat[a], 1'b1};
         rel_full[a] = {{2{coord[a][COORD_BITS-1]}}, coord[a]}
                     - {{2{view_pos_ff[a][COORD_BITS-1]}}, view_pos_ff[a]}
                     + WIDE_W'(rad_sat[a]);
         inside_axis[a] = !rel_full[a][WIDE_W-1] && (rel_full[a] < WIDE_W'(side[a]));
         dividend[a] = WIDE_W'(start_corner_ff[a])
                     + {{2{coord[a][COORD_BITS-1]}}, coord[a]}
                     - {{2{view_pos_ff[a][COORD_BITS-1]}}, view_pos_ff[a]};
         scm[a] = reduce_mod(start_corner_ff[a], side[a]);
         slot_sum[a] = {1'b0, scm_ff[a]} + {1'b0, rel_ff[a]};
         slot_next[a] = (slot_sum[a] >= {1'b0, side[a]})
                      ? SW'(slot_sum[a] - {1'b0, side[a]}) : SW'(slot_sum[a]);
      end
   end

   // Flattened slot address: y plane, then x row, then z
   assign addr_full = FAW'(slot_ff[1]) * FAW'(plane_ff)
                    + FAW'(slot_ff[0]) * FAW'(side[2])
                    + FAW'(slot_ff[2]);

   // Start-corner modulo for moves
   assign mod_start = (state_ff == ST_MSTART);

   tcst_mod_unit #(
      .DW (WIDE_W),
      .SW (SW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (dividend),
      .side      (side),
      .busy      (mod_busy),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // Record store
   assign rd_rec = rec_type'(ram_rdata);

   always_comb begin
      chk_rsp              = '0;
      chk_rsp.slot_x       = SLOT_W'(slot_ff[0]);
      chk_rsp.slot_y       = SLOT_W'(slot_ff[1]);
      chk_rsp.slot_z       = SLOT_W'(slot_ff[2]);
      chk_rsp.slot_address = ADDR_OUT_W'(addr_ff);
      chk_rec              = rd_rec;
      chk_we               = 1'b0;
      priority if (req_ff.command == CMD_STORE) begin
         if ((req_ff.index_count == '0) || (req_ff.instance_count == '0)) begin
            chk_rsp.status = STATUS_IGNORED;
         end else begin
            chk_rsp.status         = STATUS_STORED;
            chk_we                 = 1'b1;
            chk_rec.valid          = 1'b1;
            chk_rec.vertex_base    = req_ff.vertex_base;
            chk_rec.first_index    = req_ff.first_index;
            chk_rec.first_instance = req_ff.first_instance;
         end
      end else if (!rd_rec.valid) begin
         chk_rsp.status = STATUS_IGNORED;
      end else begin
         chk_rsp.status               = STATUS_CLEARED;
         chk_rsp.freed_vertex_base    = rd_rec.vertex_base;
         chk_rsp.freed_first_index    = rd_rec.first_index;
         chk_rsp.freed_first_instance = rd_rec.first_instance;
         chk_we                       = 1'b1;
         chk_rec.valid                = 1'b0;
      end
   end

   assign ram_we    = (state_ff == ST_SWEEP) || ((state_ff == ST_CHECK) && chk_we);
   assign ram_waddr = (state_ff == ST_SWEEP) ? clr_addr_ff : addr_ff;
   assign ram_wdata = (state_ff == ST_SWEEP) ? '0 : MEM_W'(chk_rec);
   assign ram_re    = (state_ff == ST_READ);

   tcst_ram #(
      .WIDTH (MEM_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (addr_ff),
      .rdata (ram_rdata)
   );

   // Sequencer, window state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            radius_ff[a]       <= RADIUS_RESET;
            view_pos_ff[a]     <= '0;
            start_corner_ff[a] <= '0;
         end
      end else begin
         // Take radius writes
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_RADIUS_X: radius_ff[0] <= csr_data;
               CSR_RADIUS_Y: radius_ff[1] <= csr_data;
               CSR_RADIUS_Z: radius_ff[2] <= csr_data;
               default: ;
            endcase
         end

         // Drop the result once taken, unless the done state reloads it
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_SWEEP: begin
               clr_addr_ff <= clr_addr_ff + AW'(1);
               if (clr_addr_ff == AW'(DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff <= req_data;
                  unique case (req_data.command)
                     CMD_MOVE:  state_ff <= ST_MSTART;
                     CMD_STORE,
                     CMD_CLEAR: state_ff <= ST_REL;
                     CMD_RESERVED: begin
                        res_ff        <= '0;
                        res_ff.status <= STATUS_IGNORED;
                        state_ff      <= ST_DONE;
                     end
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_MSTART: begin
               state_ff <= ST_MWAIT;
            end
            ST_MWAIT: begin
               if (mod_done) begin
                  for (int a = 0; a < 3; a++) begin
                     start_corner_ff[a] <= mod_rem[a];
                     view_pos_ff[a]     <= coord[a];
                  end
                  res_ff        <= '0;
                  res_ff.status <= STATUS_MOVED;
                  state_ff      <= ST_DONE;
               end
            end
            ST_REL: begin
               for (int a = 0; a < 3; a++) begin
                  rel_ff[a] <= SW'(rel_full[a]);
                  scm_ff[a] <= scm[a];
               end
               inside_ff <= inside_axis[0] && inside_axis[1] && inside_axis[2];
               state_ff  <= ST_SLOT;
            end
            ST_SLOT: begin
               if (!inside_ff) begin
                  res_ff        <= '0;
                  res_ff.status <= STATUS_OUTSIDE;
                  state_ff      <= ST_DONE;
               end else begin
                  for (int a = 0; a < 3; a++) begin
                     slot_ff[a] <= slot_next[a];
                  end
                  plane_ff <= PLW'(side[0]) * PLW'(side[2]);
                  state_ff <= ST_ADDR;
               end
            end
            ST_ADDR: begin
               addr_ff  <= AW'(addr_full);
               state_ff <= ST_READ;
            end
            ST_READ: begin
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               res_ff   <= chk_rsp;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               // Hold until the result register is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_data_ff  <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // The sweep ends in idle
   a_sweep_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && clr_addr_ff == AW'(DEPTH - 1)) |=> (state_ff == ST_IDLE))
      else $error("record sweep did not end in idle");

   // A new result only comes out of the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result loaded outside the done state");

   // The modulo unit is started only when free
   a_mod_free: assert property (@(posedge clock) disable iff (reset)
      mod_start |-> !mod_busy)
      else $error("modulo unit restarted while busy");

   // Item writes to the record RAM only for slots inside the window
   a_write_inside: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff != ST_SWEEP) |-> (inside_ff && !ram_re))
      else $error("record write for a slot outside the window");

endmodule

### rtl/core/tcst_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module tcst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

### rtl/core/tcst_mod_unit.sv
// Iterative three-lane positive modulo unit, four dividend bits per cycle.
module tcst_mod_unit #(
   parameter int DW = 26,
   parameter int SW = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend [3],
   input  logic [SW-1:0] side [3],
   output logic          busy,
   output logic          done,
   output logic [SW-1:0] remainder [3]
);

   localparam int DIG  = 4;
   localparam int NDIG = (DW + DIG - 1) / DIG;
   localparam int PW   = NDIG * DIG;
   localparam int CW   = $clog2(NDIG + 1);

   logic [PW-1:0] mag_ff [3];
   logic [PW-1:0] mag_in [3];
   logic [SW-1:0] r_ff [3];
   logic [SW-1:0] r_in [3];
   logic          neg_ff [3];
   logic [DW-1:0] abs_val [3];
   logic [CW-1:0] cnt_ff;
   logic          run_ff;
   logic          done_ff;

   // Magnitude of each signed dividend
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         abs_val[a] = dividend[a][DW-1] ? (~dividend[a] + DW'(1)) : dividend[a];
      end
   end

   // Shift in four bits per lane, restoring subtract at each bit
   always_comb begin : step_lanes
      logic [SW:0]   trial;
      logic [SW-1:0] rem;
      logic [PW-1:0] m;
      for (int a = 0; a < 3; a++) begin
         rem = r_ff[a];
         m   = mag_ff[a];
         for (int k = 0; k < DIG; k++) begin
            trial = {rem, m[PW-1]};
            if (trial >= {1'b0, side[a]}) begin
               trial = trial - {1'b0, side[a]};
            end
            rem = trial[SW-1:0];
            m   = m << 1;
         end
         r_in[a]   = rem;
         mag_in[a] = m;
      end
   end

   // Sequence the digit steps
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            for (int a = 0; a < 3; a++) begin
               neg_ff[a] <= dividend[a][DW-1];
               mag_ff[a] <= PW'(abs_val[a]);
               r_ff[a]   <= '0;
            end
            cnt_ff <= CW'(NDIG);
            run_ff <= 1'b1;
         end else if (run_ff) begin
            for (int a = 0; a < 3; a++) begin
               mag_ff[a] <= mag_in[a];
               r_ff[a]   <= r_in[a];
            end
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Fold negative dividends back into range
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         remainder[a] = (neg_ff[a] && (r_ff[a] != '0)) ? (side[a] - r_ff[a]) : r_ff[a];
      end
   end

   assign busy = run_ff;
   assign done = done_ff;

endmodule

### tb/tcst_result_monitor.sv
// Result monitor of the toroidal chunk slot table: predicts each result and compares it.
module tcst_result_monitor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  tcst_pkg::req_type                   req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  tcst_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [tcst_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tcst_pkg::RADIUS_W-1:0]       csr_data,
   output int                                  fail_count,
   output int                                  pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import tcst_pkg::*;

   localparam int SIDE_MAX    = 2 * DEF_MAX_RADIUS + 1;
   localparam int STORE_DEPTH = SIDE_MAX * SIDE_MAX * SIDE_MAX;

   // Window state and configuration as the block should hold them
   longint view_at [3];
   longint corner [3];
   int     radius [3];

   // Record store, addressed by flattened slot address
   logic [WORD_W-1:0] held_index_count   [STORE_DEPTH];
   logic [WORD_W-1:0] held_first_index   [STORE_DEPTH];
   logic [WORD_W-1:0] held_vertex_base   [STORE_DEPTH];
   logic [WORD_W-1:0] held_first_instance[STORE_DEPTH];

   rsp_type awaited_results [$];
   int      mismatches;

   // Work out the result of one request and apply its effect on the window and store
   function automatic rsp_type predict_slot_result(req_type r);
      rsp_type res;
      longint  coord [3];
      longint  side [3];
      longint  slot [3];
      longint  rel;
      longint  wrapped;
      int      addr;
      bit      in_window;
      res = '0;
      in_window = 1'b1;
      coord[0] = $signed(r.coord_x);
      coord[1] = $signed(r.coord_y);
      coord[2] = $signed(r.coord_z);
      for (int a = 0; a < 3; a++) side[a] = 2 * radius[a] + 1;
      case (r.command)
         CMD_MOVE: begin
            // shift the start corner by the view delta, kept positive modulo the side
            for (int a = 0; a < 3; a++) begin
               wrapped = (corner[a] + coord[a] - view_at[a]) % side[a];
               if (wrapped < 0) wrapped += side[a];
               corner[a] = wrapped;
               view_at[a] = coord[a];
            end
            res.status = STATUS_MOVED;
         end
         CMD_STORE, CMD_CLEAR: begin
            // locate the chunk relative to the window's low corner
            for (int a = 0; a < 3; a++) begin
               rel = coord[a] - view_at[a] + radius[a];
               if (rel < 0 || rel >= side[a]) in_window = 1'b0;
               else slot[a] = (corner[a] % side[a] + rel) % side[a];
            end
            if (!in_window) begin
               res.status = STATUS_OUTSIDE;
            end else begin
               addr = int'(slot[1] * side[0] * side[2] + slot[0] * side[2] + slot[2]);
               res.slot_x = SLOT_W'(slot[0]);
               res.slot_y = SLOT_W'(slot[1]);
               res.slot_z = SLOT_W'(slot[2]);
               res.slot_address = ADDR_OUT_W'(addr);
               if (r.command == CMD_STORE) begin
                  if (r.index_count == '0 || r.instance_count == '0) begin
                     res.status = STATUS_IGNORED;
                  end else begin
                     // overwrite without freeing whatever was there
                     held_index_count[addr] = r.index_count;
                     held_first_index[addr] = r.first_index;
                     held_vertex_base[addr] = r.vertex_base;
                     held_first_instance[addr] = r.first_instance;
                     res.status = STATUS_STORED;
                  end
               end else if (held_index_count[addr] == '0) begin
                  res.status = STATUS_IGNORED;
               end else begin
                  // hand back the offsets, mark the slot empty, keep the rest
                  res.status = STATUS_CLEARED;
                  res.freed_vertex_base = held_vertex_base[addr];
                  res.freed_first_index = held_first_index[addr];
                  res.freed_first_instance = held_first_instance[addr];
                  held_index_count[addr] = '0;
               end
            end
         end
         default: begin
            res.status = STATUS_IGNORED;
         end
      endcase
      return res;
   endfunction

   function automatic int field_mismatch(string field, logic [WORD_W-1:0] want,
                                         logic [WORD_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            view_at[a] = 0;
            corner[a] = 0;
            radius[a] = int'(RADIUS_RESET);
         end
         for (int i = 0; i < STORE_DEPTH; i++) begin
            held_index_count[i] = '0;
            held_first_index[i] = '0;
            held_vertex_base[i] = '0;
            held_first_instance[i] = '0;
         end
         awaited_results.delete();
         mismatches = 0;
      end else begin
         // track radius writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RADIUS_X: radius[0] = int'(csr_data);
               CSR_RADIUS_Y: radius[1] = int'(csr_data);
               CSR_RADIUS_Z: radius[2] = int'(csr_data);
               default: ;
            endcase
         end
         // predict each accepted request
         if (req_valid && !req_stall) awaited_results.push_back(predict_slot_result(req_data));
         // compare each accepted result with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $error("result with no request awaiting one: status %0d", rsp_data.status);
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               mismatches += field_mismatch("status", WORD_W'(want.status),
                                            WORD_W'(rsp_data.status));
               mismatches += field_mismatch("slot_x", WORD_W'(want.slot_x),
                                            WORD_W'(rsp_data.slot_x));
               mismatches += field_mismatch("slot_y", WORD_W'(want.slot_y),
                                            WORD_W'(rsp_data.slot_y));
               mismatches += field_mismatch("slot_z", WORD_W'(want.slot_z),
                                            WORD_W'(rsp_data.slot_z));
               mismatches += field_mismatch("slot_address", WORD_W'(want.slot_address),
                                            WORD_W'(rsp_data.slot_address));
               mismatches += field_mismatch("freed_vertex_base", want.freed_vertex_base,
                                            rsp_data.freed_vertex_base);
               mismatches += field_mismatch("freed_first_index", want.freed_first_index,
                                            rsp_data.freed_first_index);
               mismatches += field_mismatch("freed_first_instance", want.freed_first_instance,
                                            rsp_data.freed_first_instance);
            end
         end
      end
      fail_count <= mismatches;
      pending <= awaited_results.size();
   end

endmodule

### tb/tb_toroidal_chunk_slot_table_core.sv
// Testbench top of the toroidal chunk slot table: clock, reset, stimulus and verdict.
module tb_toroidal_chunk_slot_table_core;
   timeunit 1ns;
   timeprecision 1ps;
   import tcst_pkg::*;

   localparam int     ITEMS_PER_PHASE = 220;
   localparam int     PHASES          = 6;
   localparam int     HISTORY_DEPTH   = 32;
   localparam longint COORD_MAX       = (longint'(1) << (COORD_BITS - 1)) - 1;
   localparam longint COORD_MIN       = -(longint'(1) << (COORD_BITS - 1));
   localparam logic [CSR_INDEX_W-1:0] RADIUS_REG [3] = '{CSR_RADIUS_X, CSR_RADIUS_Y,
                                                         CSR_RADIUS_Z};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_RADIUS_X;
   logic [RADIUS_W-1:0]    csr_data = '0;
   int                     fail_count;
   int                     pending;

   int     req_idle_pct = 0;
   int     rsp_idle_pct = 0;
   longint view_now [3] = '{0, 0, 0};
   int     radius_now [3] = '{7, 7, 7};
   logic [3*COORD_BITS-1:0] stored_chunks [$];

   toroidal_chunk_slot_table_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   tcst_result_monitor result_monitor (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #10ns clock = ~clock;

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // Stall the result side at random
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   // Bound the run
   initial begin
      #10ms;
      $display("Verification failed");
      $finish;
   end

   function automatic req_type chunk_request(logic [CMD_W-1:0] cmd, longint x, longint y,
                                             longint z);
      req_type r;
      r.command = cmd;
      r.coord_x = x[COORD_BITS-1:0];
      r.coord_y = y[COORD_BITS-1:0];
      r.coord_z = z[COORD_BITS-1:0];
      r.index_count = $urandom_range(32'hFFFF_FFFF, 1);
      r.instance_count = $urandom_range(32'hFFFF_FFFF, 1);
      r.first_index = $urandom;
      r.vertex_base = $urandom;
      r.first_instance = $urandom;
      return r;
   endfunction

   // Mostly stores and clears inside the window, some moves, some noise
   function automatic req_type random_request();
      req_type          r;
      logic [CMD_W-1:0] cmd;
      longint           pos [3];
      logic [3*COORD_BITS-1:0] kept;
      int roll, pick, off, axis;
      roll = $urandom_range(99);
      if (roll < 13) begin
         cmd = (roll < 8) ? CMD_W'($urandom_range(3)) : CMD_RESERVED;
         for (int a = 0; a < 3; a++) pos[a] = $urandom;
      end else if (roll < 25) begin
         cmd = CMD_MOVE;
         pick = $urandom_range(9);
         for (int a = 0; a < 3; a++) begin
            if (pick < 7) begin
               off = $urandom_range(30);
               pos[a] = view_now[a] + off - 15;
            end else if (pick < 9) begin
               pos[a] = $urandom;
            end else begin
               pos[a] = $urandom_range(1) ? COORD_MAX : COORD_MIN;
            end
         end
      end else begin
         cmd = (roll < 62) ? CMD_STORE : CMD_CLEAR;
         pick = $urandom_range(99);
         for (int a = 0; a < 3; a++) begin
            off = $urandom_range(2 * radius_now[a]);
            pos[a] = view_now[a] + off - radius_now[a];
         end
         if (pick < 6) begin
            for (int a = 0; a < 3; a++) pos[a] = $urandom;
         end else if (pick < 14) begin
            // push one axis just past the window edge
            axis = $urandom_range(2);
            off = radius_now[axis] + 1 + $urandom_range(3);
            pos[axis] = view_now[axis] + ($urandom_range(1) ? off : -off);
         end else if (stored_chunks.size() != 0 && pick < (cmd == CMD_CLEAR ? 75 : 35)) begin
            kept = stored_chunks[$urandom_range(stored_chunks.size() - 1)];
            pos[0] = $signed(kept[3*COORD_BITS-1 -: COORD_BITS]);
            pos[1] = $signed(kept[2*COORD_BITS-1 -: COORD_BITS]);
            pos[2] = $signed(kept[COORD_BITS-1:0]);
         end
      end
      r = chunk_request(cmd, pos[0], pos[1], pos[2]);
      if (cmd == CMD_STORE) begin
         pick = $urandom_range(19);
         if (pick == 0) r.index_count = '0;
         else if (pick == 1) r.instance_count = '0;
         else if (pick == 2) begin
            r.index_count = '1;
            r.instance_count = '1;
            r.first_index = '1;
            r.vertex_base = '1;
            r.first_instance = '1;
         end
      end
      return r;
   endfunction

   // Offer one request after a random gap and hold it until taken
   task automatic push_request(req_type r);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      // mirror the view and remember stored chunks for later requests
      if (r.command == CMD_MOVE) begin
         view_now[0] = $signed(r.coord_x);
         view_now[1] = $signed(r.coord_y);
         view_now[2] = $signed(r.coord_z);
      end else if (r.command == CMD_STORE && r.index_count != '0 &&
                   r.instance_count != '0) begin
         stored_chunks.push_back({r.coord_x, r.coord_y, r.coord_z});
         if (stored_chunks.size() > HISTORY_DEPTH) void'(stored_chunks.pop_front());
      end
      do @(posedge clock); while (req_stall);
   endtask

   // Hold off requests until every result has come back
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic set_radii(int rx, int ry, int rz);
      settle();
      radius_now = '{rx, ry, rz};
      for (int a = 0; a < 3; a++) begin
         csr_valid <= 1'b1;
         csr_index <= RADIUS_REG[a];
         csr_data <= RADIUS_W'(radius_now[a]);
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(int profile);
      case (profile)
         0: begin
            req_idle_pct = 23;
            rsp_idle_pct = 74;
         end
         1: begin
            req_idle_pct = 74;
            rsp_idle_pct = 23;
         end
         default: begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
      endcase
   endtask

   initial begin
      req_type r;
      do @(posedge clock); while (reset);
      set_idling(0);
      set_radii(7, 7, 7);

      // all-ones record at the view center, freed once, then found empty
      r = chunk_request(CMD_STORE, 0, 0, 0);
      r.index_count = '1;
      r.instance_count = '1;
      r.first_index = '1;
      r.vertex_base = '1;
      r.first_instance = '1;
      push_request(r);
      push_request(chunk_request(CMD_CLEAR, 0, 0, 0));
      push_request(chunk_request(CMD_CLEAR, 0, 0, 0));
      // zero counts are dropped
      r = chunk_request(CMD_STORE, 1, 1, 1);
      r.index_count = '0;
      push_request(r);
      r = chunk_request(CMD_STORE, 1, 1, 1);
      r.instance_count = '0;
      push_request(r);
      // window edges, inside and just outside
      push_request(chunk_request(CMD_STORE, 7, 7, 7));
      push_request(chunk_request(CMD_STORE, -7, -7, -7));
      push_request(chunk_request(CMD_STORE, 8, 0, 0));
      push_request(chunk_request(CMD_CLEAR, 0, -8, 0));
      // unused command
      r = chunk_request(CMD_RESERVED, -1, -1, -1);
      r.index_count = '1;
      r.first_index = '1;
      r.vertex_base = '1;
      r.first_instance = '1;
      push_request(r);
      // overwrite an occupied slot, then free the later record
      push_request(chunk_request(CMD_STORE, 1, 2, 3));
      push_request(chunk_request(CMD_STORE, 1, 2, 3));
      push_request(chunk_request(CMD_CLEAR, 1, 2, 3));
      // the record stays in its slot while the view moves around it
      push_request(chunk_request(CMD_STORE, -4, -4, -4));
      push_request(chunk_request(CMD_MOVE, 3, 3, 3));
      push_request(chunk_request(CMD_CLEAR, -4, -4, -4));
      // coordinate extremes
      push_request(chunk_request(CMD_MOVE, COORD_MAX, COORD_MIN, 1));
      push_request(chunk_request(CMD_STORE, COORD_MAX, COORD_MIN, 1));
      push_request(chunk_request(CMD_STORE, COORD_MAX - 7, COORD_MIN + 6, 8));
      push_request(chunk_request(CMD_CLEAR, COORD_MIN, COORD_MAX, 1));
      push_request(chunk_request(CMD_MOVE, COORD_MIN, COORD_MAX, 0));
      push_request(chunk_request(CMD_CLEAR, COORD_MAX, COORD_MIN, 1));
      push_request(chunk_request(CMD_MOVE, 0, 0, 0));

      // random phases, each under its own window shape, with the idling shared by pairs of phases
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: set_radii(0, 0, 0);
            1: set_radii(2, 5, 1);
            2: set_radii(7, 0, 3);
            4: set_radii(1, 7, 6);
            default: set_radii($urandom_range(7), $urandom_range(7), $urandom_range(7));
         endcase
         set_idling(phase / 2);
         repeat (ITEMS_PER_PHASE) push_request(random_request());
      end

      settle();
      repeat (30) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
